// ----- design/mkd_pkg.sv -----
`default_nettype none
package mkd_pkg;

    localparam int unsigned NUM_COLS = 4;
    localparam int unsigned NUM_ROWS = 4;

    localparam logic [3:0] ROWS_RELEASED = 4'hF;
    localparam logic [4:0] NO_KEY        = 5'h11;

    // key codes by column, then by row
    localparam logic [4:0] KEY_TABLE [0:NUM_COLS-1][0:NUM_ROWS-1] = '{
        '{5'd1, 5'd5, 5'd9,  5'd12},
        '{5'd2, 5'd6, 5'd0,  5'd13},
        '{5'd3, 5'd7, 5'd10, 5'd14},
        '{5'd4, 5'd8, 5'd11, 5'd15}
    };

    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_DETECT  = 2'd1;
    localparam logic [1:0] PHASE_CONFIRM = 2'd2;
    localparam logic [1:0] PHASE_WAIT    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_DETECT  = 4'b0010,
        ST_CONFIRM = 4'b0100,
        ST_WAIT    = 4'b1000
    } t_phase;

    typedef logic [NUM_COLS-1:0][3:0] t_col_rows;

    typedef struct packed {
        logic [3:0] confirmed_key;
        logic       key_valid;
        logic [4:0] decoded_key;
        logic [1:0] phase;
    } t_status;

endpackage
`default_nettype wire

// ----- design/matrix_keypad_debounce_scanner.sv -----
`default_nettype none
// 4x4 matrix keypad scanner with four-phase debounce, one scan tick per input
// transaction. Each tick carries the row levels read with all columns low and
// with each single column low; the block decodes the key (17 when no single
// key is found), steps the idle/detect/confirm/wait-release sequence and
// returns one result transaction showing the state after that tick. A tick is
// accepted every clock cycle unless the output stalls; each tick moves from the
// input register through the decode and the debounce update into the debounce
// registers, which are the result register. Stalls on the output hold the
// input side after one further tick has been taken.
module matrix_keypad_debounce_scanner
    import mkd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire [3:0]  i_rows_all_columns,
    input  wire [3:0]  i_rows_column_one,
    input  wire [3:0]  i_rows_column_two,
    input  wire [3:0]  i_rows_column_three,
    input  wire [3:0]  i_rows_column_four,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [3:0] o_confirmed_key,
    output logic       o_key_valid,
    output logic [4:0] o_decoded_key,
    output logic [1:0] o_phase
);

    logic       r_in_valid;
    logic [3:0] r_rows_all;
    t_col_rows  r_col_rows;
    logic       r_out_valid;
    logic       w_step;
    logic [4:0] w_code;
    t_status    w_status;

    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_rows_all    <= i_rows_all_columns;
            r_col_rows[0] <= i_rows_column_one;
            r_col_rows[1] <= i_rows_column_two;
            r_col_rows[2] <= i_rows_column_three;
            r_col_rows[3] <= i_rows_column_four;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    mkd_decode u_decode (
        .i_col_rows (r_col_rows),
        .o_code     (w_code)
    );

    mkd_debounce u_debounce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_released (r_rows_all == ROWS_RELEASED),
        .i_code     (w_code),
        .o_status   (w_status)
    );

    assign o_out_valid     = r_out_valid;
    assign o_confirmed_key = w_status.confirmed_key;
    assign o_key_valid     = w_status.key_valid;
    assign o_decoded_key   = w_status.decoded_key;
    assign o_phase         = w_status.phase;

endmodule
`default_nettype wire

// ----- design/mkd_decode.sv -----
`default_nettype none
module mkd_decode
    import mkd_pkg::*;
(
    input  wire t_col_rows  i_col_rows,
    output logic [4:0]      o_code
);

    // later columns override earlier ones
    always_comb begin
        o_code = NO_KEY;
        for (int col = 0; col < NUM_COLS; col++) begin
            for (int row = 0; row < NUM_ROWS; row++) begin
                if (i_col_rows[col] == ~(4'b0001 << row)) begin
                    o_code = KEY_TABLE[col][row];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/mkd_debounce.sv -----
`default_nettype none
module mkd_debounce
    import mkd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_step,
    input  wire        i_released,
    input  wire [4:0]  i_code,
    output t_status    o_status
);

    t_phase     r_phase,     n_phase;
    logic [4:0] r_held,      n_held;
    logic [4:0] r_last,      n_last;
    logic       r_valid,     n_valid;
    logic [3:0] r_confirmed, n_confirmed;

    always_comb begin
        n_phase     = r_phase;
        n_held      = r_held;
        n_last      = r_last;
        n_valid     = r_valid;
        n_confirmed = r_confirmed;
        case (r_phase)
            ST_IDLE: begin
                if (i_released) begin
                    n_valid = 1'b0;
                    n_held  = '0;
                end else begin
                    n_phase = ST_DETECT;
                end
            end
            ST_DETECT: begin
                if (i_released) begin
                    n_phase = ST_IDLE;
                    n_valid = 1'b0;
                    n_held  = '0;
                end else begin
                    n_last = i_code;
                    if (i_code == NO_KEY) begin
                        n_phase = ST_IDLE;
                        n_valid = 1'b0;
                        n_held  = '0;
                    end else begin
                        n_phase = ST_CONFIRM;
                        n_held  = i_code;
                    end
                end
            end
            ST_CONFIRM: begin
                if (i_released) begin
                    n_phase = ST_IDLE;
                    n_valid = 1'b0;
                    n_held  = '0;
                end else begin
                    n_last = i_code;
                    if (r_held == i_code) begin
                        n_phase     = ST_WAIT;
                        n_valid     = 1'b1;
                        n_confirmed = i_code[3:0];
                    end else begin
                        n_phase = ST_IDLE;
                        n_valid = 1'b0;
                        n_held  = '0;
                    end
                end
            end
            ST_WAIT: begin
                if (i_released) begin
                    n_phase = ST_IDLE;
                    n_held  = r_last;
                end
            end
            default: begin
                n_phase = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ST_IDLE;
            r_held      <= '0;
            r_last      <= '0;
            r_valid     <= 1'b0;
            r_confirmed <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_last      <= n_last;
            r_valid     <= n_valid;
            r_confirmed <= n_confirmed;
        end
    end

    always_comb begin
        o_status.confirmed_key = r_confirmed;
        o_status.key_valid     = r_valid;
        o_status.decoded_key   = r_last;
        case (r_phase)
            ST_IDLE:    o_status.phase = PHASE_IDLE;
            ST_DETECT:  o_status.phase = PHASE_DETECT;
            ST_CONFIRM: o_status.phase = PHASE_CONFIRM;
            ST_WAIT:    o_status.phase = PHASE_WAIT;
            default:    o_status.phase = PHASE_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/mkd_checker.sv -----
`default_nettype none
module mkd_checker
    import mkd_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_ready,
    input wire [3:0] i_rows_all_columns,
    input wire [3:0] i_rows_column_one,
    input wire [3:0] i_rows_column_two,
    input wire [3:0] i_rows_column_three,
    input wire [3:0] i_rows_column_four,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire [3:0] o_confirmed_key,
    input wire       o_key_valid,
    input wire [4:0] o_decoded_key,
    input wire [1:0] o_phase
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_confirmed_key)
            && $stable(o_key_valid) && $stable(o_decoded_key) && $stable(o_phase))
        else $error("result changed while stalled");

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_rows_all_columns)
            && $stable(i_rows_column_one) && $stable(i_rows_column_two)
            && $stable(i_rows_column_three) && $stable(i_rows_column_four))
        else $error("input changed while stalled");

    // confirm phase is only reached with a real key
    a_confirm_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_phase == PHASE_CONFIRM |-> o_decoded_key != NO_KEY)
        else $error("confirm phase without a key");

    // waiting for release shows the latched key
    a_wait_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_phase == PHASE_WAIT |->
            o_key_valid && o_decoded_key == {1'b0, o_confirmed_key})
        else $error("latched key mismatch while waiting for release");

endmodule

bind matrix_keypad_debounce_scanner mkd_checker u_mkd_checker (.*);
`default_nettype wire

// ----- tb/keypad_debounce_checker.sv -----
`timescale 1ns / 1ps
module keypad_debounce_checker
    import mkd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  wire [3:0]  i_rows_all_columns,
    input  wire [3:0]  i_rows_column_one,
    input  wire [3:0]  i_rows_column_two,
    input  wire [3:0]  i_rows_column_three,
    input  wire [3:0]  i_rows_column_four,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  wire [3:0]  i_confirmed_key,
    input  wire        i_key_valid,
    input  wire [4:0]  i_decoded_key,
    input  wire [1:0]  i_phase,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_ticks_seen,
    output int         o_results_checked,
    output int         o_keys_confirmed
);

    localparam logic [4:0] KEY_CODES [0:NUM_COLS-1][0:NUM_ROWS-1] = '{
        '{5'd1, 5'd5, 5'd9,  5'd12},
        '{5'd2, 5'd6, 5'd0,  5'd13},
        '{5'd3, 5'd7, 5'd10, 5'd14},
        '{5'd4, 5'd8, 5'd11, 5'd15}
    };

    logic [1:0] phase_q     = PHASE_IDLE;
    logic [4:0] held_code   = '0;
    logic [4:0] last_code   = '0;
    logic       valid_flag  = 1'b0;
    logic [3:0] latched_key = '0;
    t_status    status_q [$];

    // later columns override earlier ones
    function automatic logic [4:0] decode_key(t_col_rows cols);
        logic [4:0] code;
        logic [3:0] one_low;
        code = NO_KEY;
        for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                one_low = ~(4'b0001 << r);
                if (cols[c] == one_low) begin
                    code = KEY_CODES[c][r];
                end
            end
        end
        return code;
    endfunction

    function automatic void clear_press();
        phase_q    = PHASE_IDLE;
        valid_flag = 1'b0;
        held_code  = '0;
    endfunction

    function automatic t_status predict_tick(logic [3:0] all_rows, t_col_rows cols);
        logic       released;
        logic [4:0] code;
        t_status    s;
        released = (all_rows == ROWS_RELEASED);
        code     = decode_key(cols);
        case (phase_q)
            PHASE_IDLE: begin
                if (released) begin
                    clear_press();
                end else begin
                    phase_q = PHASE_DETECT;
                end
            end
            PHASE_DETECT: begin
                if (released) begin
                    clear_press();
                end else begin
                    phase_q   = PHASE_CONFIRM;
                    last_code = code;
                    if (code == NO_KEY) begin
                        clear_press();
                    end else begin
                        held_code = code;
                    end
                end
            end
            PHASE_CONFIRM: begin
                if (released) begin
                    clear_press();
                end else begin
                    last_code = code;
                    if (held_code == code) begin
                        phase_q     = PHASE_WAIT;
                        valid_flag  = 1'b1;
                        latched_key = code[3:0];
                        o_keys_confirmed++;
                    end else begin
                        clear_press();
                    end
                end
            end
            default: begin
                if (released) begin
                    phase_q   = PHASE_IDLE;
                    held_code = last_code;
                end
            end
        endcase
        s.confirmed_key = latched_key;
        s.key_valid     = valid_flag;
        s.decoded_key   = last_code;
        s.phase         = phase_q;
        return s;
    endfunction

    function automatic bit field_ok(string name, logic [4:0] want, logic [4:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_status want;
        if (!i_rst_n) begin
            phase_q     = PHASE_IDLE;
            held_code   = '0;
            last_code   = '0;
            valid_flag  = 1'b0;
            latched_key = '0;
            status_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                status_q.push_back(predict_tick(i_rows_all_columns,
                    {i_rows_column_four, i_rows_column_three,
                     i_rows_column_two, i_rows_column_one}));
                o_ticks_seen++;
            end
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    $error("result transaction with no tick outstanding");
                    o_fail_count++;
                end else begin
                    want = status_q.pop_front();
                    if (!(field_ok("confirmed_key", 5'(want.confirmed_key),
                                   5'(i_confirmed_key))
                          & field_ok("key_valid", 5'(want.key_valid), 5'(i_key_valid))
                          & field_ok("decoded_key", want.decoded_key, i_decoded_key)
                          & field_ok("phase", 5'(want.phase), 5'(i_phase)))) begin
                        o_fail_count++;
                    end
                    o_results_checked++;
                end
            end
        end
        o_pending = status_q.size();
    end

endmodule

// ----- tb/tb_matrix_keypad_debounce_scanner.sv -----
`timescale 1ns / 1ps
module tb_matrix_keypad_debounce_scanner;
    import mkd_pkg::*;

    localparam int TICKS_PER_PHASE = 530;
    localparam int HOLD_CYCLES     = 60;

    logic       i_clk               = 1'b0;
    logic       i_rst_n             = 1'b0;
    logic       i_in_valid          = 1'b0;
    logic [3:0] i_rows_all_columns  = ROWS_RELEASED;
    logic [3:0] i_rows_column_one   = 4'hF;
    logic [3:0] i_rows_column_two   = 4'hF;
    logic [3:0] i_rows_column_three = 4'hF;
    logic [3:0] i_rows_column_four  = 4'hF;
    logic       i_out_ready         = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [3:0] o_confirmed_key;
    logic       o_key_valid;
    logic [4:0] o_decoded_key;
    logic [1:0] o_phase;

    int fail_count;
    int pending;
    int ticks_seen;
    int results_checked;
    int keys_confirmed;
    int ticks_sent    = 0;
    int send_idle_pct = 26;
    int recv_idle_pct = 55;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    matrix_keypad_debounce_scanner DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rows_all_columns  (i_rows_all_columns),
        .i_rows_column_one   (i_rows_column_one),
        .i_rows_column_two   (i_rows_column_two),
        .i_rows_column_three (i_rows_column_three),
        .i_rows_column_four  (i_rows_column_four),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_confirmed_key     (o_confirmed_key),
        .o_key_valid         (o_key_valid),
        .o_decoded_key       (o_decoded_key),
        .o_phase             (o_phase)
    );

    keypad_debounce_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_rows_all_columns  (i_rows_all_columns),
        .i_rows_column_one   (i_rows_column_one),
        .i_rows_column_two   (i_rows_column_two),
        .i_rows_column_three (i_rows_column_three),
        .i_rows_column_four  (i_rows_column_four),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_confirmed_key     (o_confirmed_key),
        .i_key_valid         (o_key_valid),
        .i_decoded_key       (o_decoded_key),
        .i_phase             (o_phase),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_ticks_seen        (ticks_seen),
        .o_results_checked   (results_checked),
        .o_keys_confirmed    (keys_confirmed)
    );

    // result side: random back-pressure plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            holds_done  <= 0;
            hold_left   <= 0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            i_out_ready <= 1'b0;
            holds_done  <= holds_done + 1;
            hold_left   <= HOLD_CYCLES - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [3:0] row_low(int row);
        return ~(4'b0001 << row);
    endfunction

    function automatic t_col_rows single_key(int col, int row);
        t_col_rows cols;
        cols      = {NUM_COLS{4'hF}};
        cols[col] = row_low(row);
        return cols;
    endfunction

    task automatic send_tick(logic [3:0] all_rows, t_col_rows cols);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_rows_all_columns  <= all_rows;
        i_rows_column_one   <= cols[0];
        i_rows_column_two   <= cols[1];
        i_rows_column_three <= cols[2];
        i_rows_column_four  <= cols[3];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic hold_key(int col, int row, int n);
        repeat (n) send_tick(row_low(row), single_key(col, row));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        wait (ticks_seen == ticks_sent && pending == 0);
    endtask

    // one press with bounce, smear and glitches mixed in, then release
    task automatic random_press();
        int         col;
        int         row;
        int         len;
        int         mode;
        t_col_rows  cols;
        logic [3:0] all_rows;
        col = $urandom_range(3);
        row = $urandom_range(3);
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
            cols     = single_key(col, row);
            all_rows = row_low(row);
            mode     = $urandom_range(99);
            if (mode < 6) begin
                col  = $urandom_range(3);
                row  = $urandom_range(3);
                cols = single_key(col, row);
            end else if (mode < 10) begin
                cols[col] = 4'($urandom_range(15));
            end else if (mode < 13) begin
                all_rows = ROWS_RELEASED;
            end else if (mode < 30 && col > 0) begin
                cols[$urandom_range(col - 1)] = row_low($urandom_range(3));
            end
            if (mode >= 13 && $urandom_range(3) == 0) begin
                all_rows = 4'($urandom_range(14));
            end
            send_tick(all_rows, cols);
        end
        repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(1) == 0) begin
                send_tick(ROWS_RELEASED, t_col_rows'($urandom));
            end else begin
                send_tick(ROWS_RELEASED, {NUM_COLS{4'hF}});
            end
        end
    endtask

    initial begin
        int        target;
        bit        held;
        t_col_rows cols;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_tick(ROWS_RELEASED, {NUM_COLS{4'hF}});
        hold_key(0, 0, 4);
        send_tick(ROWS_RELEASED, '0);
        hold_key(1, 2, 3);
        send_tick(ROWS_RELEASED, {NUM_COLS{4'hF}});
        send_tick(ROWS_RELEASED, {NUM_COLS{4'hF}});
        // column four wins over column one
        cols    = single_key(3, 3);
        cols[0] = row_low(1);
        repeat (3) send_tick(4'h0, cols);
        send_tick(ROWS_RELEASED, {NUM_COLS{4'hF}});
        // every row low in every column, nothing decodes
        repeat (2) send_tick(4'h0, '0);
        // code changes between detect and confirm
        hold_key(3, 0, 2);
        send_tick(row_low(1), single_key(3, 1));
        // release during detect, then during confirm
        send_tick(4'hE, single_key(2, 2));
        send_tick(ROWS_RELEASED, {NUM_COLS{4'hF}});
        hold_key(2, 1, 2);
        send_tick(ROWS_RELEASED, {NUM_COLS{4'hF}});
        wait_for_results();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = ticks_sent + TICKS_PER_PHASE;
            held   = 1'b0;
            while (ticks_sent < target) begin
                if (!held && ticks_sent > target - TICKS_PER_PHASE / 2) begin
                    hold_requests++;
                    held = 1'b1;
                end
                if ($urandom_range(99) < 15) begin
                    send_tick(4'($urandom_range(15)), t_col_rows'($urandom));
                end else begin
                    random_press();
                end
            end
            wait_for_results();
        end

        repeat (6) @(posedge i_clk);
        $display("%0d scan ticks driven, %0d results compared, %0d presses confirmed",
                 ticks_sent, results_checked, keys_confirmed);
        $display("included bounces, column overrides, releases in each phase and stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
